[rtl/core/circle_pair_collision_response_unit_assert.svh]
// Assertion macros shared by the collision response unit.
`ifndef CIRCLE_PAIR_COLLISION_RESPONSE_UNIT_ASSERT_SVH
`define CIRCLE_PAIR_COLLISION_RESPONSE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPCR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CPCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/cpcr_pkg.sv]
// Types, codes and fixed pipeline constants of the collision response unit.
package cpcr_pkg;

  localparam logic [13:0] RADIUS_RESET = 14'd3072;
  localparam logic [15:0] RESTITUTION_RESET = 16'd64225;

  // Register indexes on the configuration port.
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_RESTITUTION = 1'b1;

  localparam int unsigned D2_W = 30;

  // Back-end pipeline layout (stage register indexes).
  localparam int unsigned SQRT_STEPS = 31;
  localparam int unsigned ROOT_W = 31;
  localparam int unsigned SQ_REM_W = 33;
  localparam int unsigned D2_PAIRS = 15;
  localparam int unsigned IDIV_STEPS = 19;
  localparam int unsigned PDIV_STEPS = 16;
  localparam int unsigned SQ_END = SQRT_STEPS;
  localparam int unsigned I_RND = 3;
  localparam int unsigned I_END = I_RND + IDIV_STEPS;
  localparam int unsigned P_MUL = SQ_END + 1;
  localparam int unsigned P_RND = P_MUL + 1;
  localparam int unsigned P_END = P_RND + PDIV_STEPS;
  localparam int unsigned FRONT_STAGES = 2;

  typedef struct packed {
    logic signed [19:0] first_x;
    logic signed [19:0] first_y;
    logic signed [15:0] first_vx;
    logic signed [15:0] first_vy;
    logic signed [19:0] second_x;
    logic signed [19:0] second_y;
    logic signed [15:0] second_vx;
    logic signed [15:0] second_vy;
    logic               first_live;
    logic               second_live;
  } cpcr_in_t;

  typedef struct packed {
    logic signed [19:0] new_first_x;
    logic signed [19:0] new_first_y;
    logic signed [15:0] new_first_vx;
    logic signed [15:0] new_first_vy;
    logic signed [19:0] new_second_x;
    logic signed [19:0] new_second_y;
    logic signed [15:0] new_second_vx;
    logic signed [15:0] new_second_vy;
    logic               overlapped;
    logic               impulse_done;
  } cpcr_out_t;

  typedef struct packed {
    logic [13:0] contact_radius;
    logic [15:0] restitution;
  } cpcr_cfg_t;

  // One classified pair as it waits in the queue.
  typedef struct packed {
    cpcr_in_t         item;
    logic             contact;
    logic             approach;
    logic [1:0]       axis_neg;
    logic [1:0][14:0] axis_abs;
    logic [D2_W-1:0]  d2;
    logic [31:0]      mdot;
  } cpcr_job_t;

endpackage

[rtl/core/circle_pair_collision_response_unit.sv]
// Top level of the equal-mass disc pair collision response unit.
//
// The unit takes one pair of equal-mass discs per transaction and returns one
// result transaction per pair, in order. A pair in contact (both discs live,
// centre distance above zero and below twice the contact radius) is pushed
// apart by half the overlap along the normal, and when the discs approach,
// an impulse scaled by (1 + restitution) / 2 is exchanged; all other pairs
// pass through unchanged. Throughput is one pair per clock cycle while the
// result side takes every result. A pair passes 54 register stages, the
// first of them loaded at the edge that accepts it. These are the two
// front-end classification stages, the queue store, the back-end input
// register, the 31-stage square root pipeline, two multiply and rounding
// stages, the 16-stage position divider and the output register. The impulse
// divider (19 stages) runs alongside the square root. A cycle in which a
// waiting result is not taken holds the whole back end for that cycle. The
// queue holds QUEUE_DEPTH pairs, so the front end keeps accepting for a while
// after the result side stalls. Configuration writes go through the
// APB-style port and must only happen while no pair is in flight.
`include "circle_pair_collision_response_unit_assert.svh"

module circle_pair_collision_response_unit import cpcr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  cpcr_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output cpcr_out_t   out_data_o
);

  // Upper bound on pairs held anywhere inside the unit at once.
  localparam int unsigned INFLIGHT_CAP = FRONT_STAGES + QUEUE_DEPTH + (P_END + 1) + 1;
  localparam int unsigned INF_W = $clog2(INFLIGHT_CAP + 1);

  cpcr_cfg_t cfg;
  logic      fq_valid, fq_ready;
  cpcr_job_t fq_job;
  logic      qb_valid, qb_ready;
  cpcr_job_t qb_job;

  // Configuration registers; the front and back ends read them directly.
  cpcr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Front end: differences, squared distance, contact and approach tests.
  cpcr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (fq_valid),
    .job_ready_i (fq_ready),
    .job_o       (fq_job)
  );

  // The queue lets the front end run on while the back end is stalled.
  cpcr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_job),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_job)
  );

  // Back end: distance, separation, impulse and the output register.
  cpcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_valid_i (qb_valid),
    .job_ready_o (qb_ready),
    .job_i       (qb_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Count of pairs accepted whose results have not been taken yet.
  logic [INF_W-1:0] inflight_q;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   inflight_q <= inflight_q + 1'b1;
        2'b01:   inflight_q <= inflight_q - 1'b1;
        default: inflight_q <= inflight_q;
      endcase
    end
  end

  // An impulse is only ever applied to a pair that was also separated.
  `CPCR_ASSERT_NOW(a_impulse_implies_overlap, clk_i, rst_ni, out_valid_o, !out_data_o.impulse_done || out_data_o.overlapped, "impulse applied without overlap")
  // A result is never offered without a pair having been accepted for it.
  `CPCR_ASSERT_NOW(a_no_phantom_result, clk_i, rst_ni, out_valid_o, inflight_q != '0, "result offered with no pair in flight")
  // The unit never holds more pairs than its storage can carry.
  `CPCR_ASSERT_NOW(a_inflight_bounded, clk_i, rst_ni, 1'b1, inflight_q <= INF_W'(INFLIGHT_CAP), "more pairs in flight than storage")
  // Once the last pair is delivered and nothing new came in, the output goes quiet.
  `CPCR_ASSERT_NEXT(a_drained_goes_idle, clk_i, rst_ni, out_acc && !in_acc && (inflight_q == INF_W'(1)), !out_valid_o, "result offered after unit drained")

endmodule

[rtl/core/cpcr_cfg.sv]
// APB-style configuration registers: contact radius and restitution.
module cpcr_cfg import cpcr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cpcr_cfg_t   cfg_o
);

  logic [13:0] radius_q;
  logic [15:0] restit_q;
  logic        wr_en;
  logic        reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
      restit_q <= RESTITUTION_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RADIUS:      radius_q <= pwdata[13:0];
        REG_RESTITUTION: restit_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RADIUS:      prdata = {18'd0, radius_q};
      REG_RESTITUTION: prdata = {16'd0, restit_q};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.contact_radius = radius_q;
  assign cfg_o.restitution    = restit_q;

endmodule

[rtl/core/cpcr_front.sv]
// Front end: takes pairs, runs the exact contact and approach tests.
module cpcr_front import cpcr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cpcr_cfg_t cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  cpcr_in_t  in_data_i,
  output logic      job_valid_o,
  input  logic      job_ready_i,
  output cpcr_job_t job_o
);

  logic signed [20:0] dx, dy;
  logic signed [16:0] dvx, dvy;
  logic signed [41:0] sqx, sqy;
  logic signed [37:0] px, py;

  logic               a_vld_q;
  cpcr_in_t           a_item_q;
  logic signed [20:0] a_dx_q, a_dy_q;
  logic [40:0]        a_sqx_q, a_sqy_q;
  logic signed [37:0] a_px_q, a_py_q;
  logic [27:0]        a_rr_q;

  logic               b_vld_q;
  cpcr_job_t          b_job_q;
  logic               a_ready, b_ready;

  logic [41:0]        d2, lim;
  logic signed [38:0] dot;
  logic [38:0]        mdot_full;
  logic [20:0]        adx_full, ady_full;
  cpcr_job_t          job_d;

  assign dx  = 21'(in_data_i.second_x) - 21'(in_data_i.first_x);
  assign dy  = 21'(in_data_i.second_y) - 21'(in_data_i.first_y);
  assign dvx = 17'(in_data_i.second_vx) - 17'(in_data_i.first_vx);
  assign dvy = 17'(in_data_i.second_vy) - 17'(in_data_i.first_vy);
  assign sqx = dx * dx;
  assign sqy = dy * dy;
  assign px  = dvx * dx;
  assign py  = dvy * dy;

  assign b_ready    = !b_vld_q || job_ready_i;
  assign a_ready    = !a_vld_q || b_ready;
  assign in_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (a_ready) a_vld_q <= in_valid_i;
      if (b_ready) b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_item_q <= in_data_i;
      a_dx_q   <= dx;
      a_dy_q   <= dy;
      a_sqx_q  <= sqx[40:0];
      a_sqy_q  <= sqy[40:0];
      a_px_q   <= px;
      a_py_q   <= py;
      a_rr_q   <= cfg_i.contact_radius * cfg_i.contact_radius;
    end
    if (b_ready && a_vld_q) begin
      b_job_q <= job_d;
    end
  end

  // Contact needs 0 < d2 < (2r)^2; approach is a non-positive normal speed.
  assign d2        = {1'b0, a_sqx_q} + {1'b0, a_sqy_q};
  assign lim       = {12'd0, a_rr_q, 2'b00};
  assign dot       = 39'(a_px_q) + 39'(a_py_q);
  assign mdot_full = 39'(-dot);
  assign adx_full  = a_dx_q[20] ? 21'(-a_dx_q) : 21'(a_dx_q);
  assign ady_full  = a_dy_q[20] ? 21'(-a_dy_q) : 21'(a_dy_q);

  always_comb begin
    job_d             = '0;
    job_d.item        = a_item_q;
    job_d.contact     = a_item_q.first_live && a_item_q.second_live &&
                        (d2 != '0) && (d2 < lim);
    job_d.approach    = dot[38] || (dot == '0);
    job_d.axis_neg[0] = a_dx_q[20];
    job_d.axis_neg[1] = a_dy_q[20];
    job_d.axis_abs[0] = adx_full[14:0];
    job_d.axis_abs[1] = ady_full[14:0];
    job_d.d2          = d2[D2_W-1:0];
    job_d.mdot        = mdot_full[31:0];
  end

  assign job_valid_o = b_vld_q;
  assign job_o       = b_job_q;

endmodule

[rtl/core/cpcr_queue.sv]
// Short queue of classified pairs between the front and back ends.
module cpcr_queue import cpcr_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  cpcr_job_t push_data_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output cpcr_job_t pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cpcr_job_t        store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             full, empty, push, pop;

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);
  assign push  = push_valid_i && !full;
  assign pop   = pop_ready_i && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) store_q[wr_ptr_q] <= push_data_i;
  end

  assign push_ready_o = !full;
  assign pop_valid_o  = !empty;
  assign pop_data_o   = store_q[rd_ptr_q];

endmodule

[rtl/core/cpcr_back.sv]
// Back end: pipelined square root, dividers and the saturating update.
module cpcr_back import cpcr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cpcr_cfg_t cfg_i,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  input  cpcr_job_t job_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output cpcr_out_t out_data_o
);

  localparam int unsigned IPROD_W = 47;
  localparam int unsigned ISPLIT  = 24;
  localparam int unsigned IHI_W   = 40;
  localparam int unsigned ILO_W   = 41;
  localparam int unsigned INUM_W  = 65;
  localparam int unsigned PPROD_W = 46;
  localparam int unsigned PNUM_W  = 47;

  logic      en;
  logic      out_vld_q;
  cpcr_out_t out_q;
  cpcr_out_t out_d;

  logic      v_q   [0:P_END];
  cpcr_job_t job_q [0:P_END];

  logic [SQ_REM_W-1:0] rem_q  [1:SQ_END];
  logic [ROOT_W-1:0]   root_q [1:SQ_END];
  logic [ROOT_W-1:0]   pd_q   [P_MUL:P_END-1];
  logic [ROOT_W-1:0]   gap;
  logic [16:0]         kfac;

  logic signed [21:0] pshift [2];
  logic signed [21:0] vshift [2];

  function automatic logic [19:0] sat_pos(input logic signed [21:0] v);
    if (v > 22'sd524287) return 20'h7FFFF;
    else if (v < -22'sd524288) return 20'h80000;
    else return v[19:0];
  endfunction

  function automatic logic [15:0] sat_vel(input logic signed [21:0] v);
    if (v > 22'sd32767) return 16'h7FFF;
    else if (v < -22'sd32768) return 16'h8000;
    else return v[15:0];
  endfunction

  // The whole back end advances together whenever the output can move.
  assign en          = !out_vld_q || out_ready_i;
  assign job_ready_o = en;
  assign kfac        = {1'b1, cfg_i.restitution};
  assign gap         = {cfg_i.contact_radius, 17'd0} - root_q[SQ_END];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= job_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) job_q[0] <= job_i;
  end

  for (genvar s = 1; s <= P_END; s++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en) begin
        v_q[s] <= v_q[s-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) job_q[s] <= job_q[s-1];
    end
  end

  // Square root of d2 * 2^32, one result bit per stage.
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [SQ_REM_W-1:0] rem_in;
    logic [ROOT_W-1:0]   root_in;
    logic [1:0]          pair;
    logic [SQ_REM_W+1:0] cur, trial;
    logic                ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k];
      assign root_in = root_q[k];
    end

    if (k < D2_PAIRS) begin : g_bits
      assign pair = job_q[k].d2[D2_W-1-2*k -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign cur   = {rem_in, pair};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[k+1]  <= ge ? SQ_REM_W'(cur - trial) : SQ_REM_W'(cur);
        root_q[k+1] <= {root_in[ROOT_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) pd_q[P_MUL] <= root_q[SQ_END];
  end

  for (genvar s = P_MUL + 1; s < P_END; s++) begin : g_dcarry
    always_ff @(posedge clk_i) begin
      if (en) pd_q[s] <= pd_q[s-1];
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_axis
    logic [IPROD_W-1:0]    ip_q;
    logic [IHI_W-1:0]      ih_q;
    logic [ILO_W-1:0]      il_q;
    logic [INUM_W-1:0]     irem_q [I_RND:I_END-1];
    logic [IDIV_STEPS-1:0] iq_q   [I_RND+1:P_END];
    logic [PPROD_W-1:0]    pp_q;
    logic [PNUM_W-1:0]     prem_q [P_RND:P_END-1];
    logic [PDIV_STEPS-1:0] pq_q   [P_RND+1:P_END];

    // Impulse numerator: mdot * |d| * (1 + e), the wide product in two halves.
    always_ff @(posedge clk_i) begin
      if (en) begin
        ip_q <= job_q[0].mdot * job_q[0].axis_abs[a];
        ih_q <= ip_q[IPROD_W-1:ISPLIT] * kfac;
        il_q <= ip_q[ISPLIT-1:0] * kfac;
        irem_q[I_RND] <= INUM_W'({ih_q, {ISPLIT{1'b0}}}) + INUM_W'(il_q) +
                         INUM_W'({job_q[I_RND-1].d2, 16'd0});
      end
    end

    for (genvar j = 0; j < IDIV_STEPS; j++) begin : g_idiv
      logic [INUM_W:0]       den_sh;
      logic [IDIV_STEPS-1:0] q_in;
      logic                  ge;

      assign den_sh = (INUM_W + 1)'({job_q[I_RND+j].d2, 17'd0}) << (IDIV_STEPS - 1 - j);
      assign ge     = ({1'b0, irem_q[I_RND+j]} >= den_sh);

      if (j == 0) begin : g_q0
        assign q_in = '0;
      end else begin : g_qn
        assign q_in = iq_q[I_RND+j];
      end

      always_ff @(posedge clk_i) begin
        if (en) iq_q[I_RND+1+j] <= {q_in[IDIV_STEPS-2:0], ge};
      end

      if (j < IDIV_STEPS - 1) begin : g_rem
        always_ff @(posedge clk_i) begin
          if (en) begin
            irem_q[I_RND+1+j] <= ge ? INUM_W'({1'b0, irem_q[I_RND+j]} - den_sh)
                                    : irem_q[I_RND+j];
          end
        end
      end
    end

    for (genvar s = I_END + 1; s <= P_END; s++) begin : g_icarry
      always_ff @(posedge clk_i) begin
        if (en) iq_q[s] <= iq_q[s-1];
      end
    end

    // Position shift: |d| * gap / (2D), rounded by adding D first.
    always_ff @(posedge clk_i) begin
      if (en) begin
        pp_q          <= job_q[SQ_END].axis_abs[a] * gap;
        prem_q[P_RND] <= PNUM_W'(pp_q) + PNUM_W'(pd_q[P_MUL]);
      end
    end

    for (genvar j = 0; j < PDIV_STEPS; j++) begin : g_pdiv
      logic [PNUM_W:0]       den_sh;
      logic [PDIV_STEPS-1:0] q_in;
      logic                  ge;

      assign den_sh = (PNUM_W + 1)'({pd_q[P_RND+j], 1'b0}) << (PDIV_STEPS - 1 - j);
      assign ge     = ({1'b0, prem_q[P_RND+j]} >= den_sh);

      if (j == 0) begin : g_q0
        assign q_in = '0;
      end else begin : g_qn
        assign q_in = pq_q[P_RND+j];
      end

      always_ff @(posedge clk_i) begin
        if (en) pq_q[P_RND+1+j] <= {q_in[PDIV_STEPS-2:0], ge};
      end

      if (j < PDIV_STEPS - 1) begin : g_rem
        always_ff @(posedge clk_i) begin
          if (en) begin
            prem_q[P_RND+1+j] <= ge ? PNUM_W'({1'b0, prem_q[P_RND+j]} - den_sh)
                                    : prem_q[P_RND+j];
          end
        end
      end
    end

    assign pshift[a] = job_q[P_END].axis_neg[a] ? -$signed(22'(pq_q[P_END]))
                                                 : $signed(22'(pq_q[P_END]));
    assign vshift[a] = job_q[P_END].axis_neg[a] ? -$signed(22'(iq_q[P_END]))
                                                 : $signed(22'(iq_q[P_END]));
  end

  always_comb begin
    cpcr_job_t j;
    j = job_q[P_END];
    out_d.new_first_x   = j.item.first_x;
    out_d.new_first_y   = j.item.first_y;
    out_d.new_second_x  = j.item.second_x;
    out_d.new_second_y  = j.item.second_y;
    out_d.new_first_vx  = j.item.first_vx;
    out_d.new_first_vy  = j.item.first_vy;
    out_d.new_second_vx = j.item.second_vx;
    out_d.new_second_vy = j.item.second_vy;
    out_d.overlapped    = j.contact;
    out_d.impulse_done  = j.contact && j.approach;
    if (j.contact) begin
      out_d.new_first_x  = sat_pos(22'(j.item.first_x) - pshift[0]);
      out_d.new_first_y  = sat_pos(22'(j.item.first_y) - pshift[1]);
      out_d.new_second_x = sat_pos(22'(j.item.second_x) + pshift[0]);
      out_d.new_second_y = sat_pos(22'(j.item.second_y) + pshift[1]);
      if (j.approach) begin
        out_d.new_first_vx  = sat_vel(22'(j.item.first_vx) - vshift[0]);
        out_d.new_first_vy  = sat_vel(22'(j.item.first_vy) - vshift[1]);
        out_d.new_second_vx = sat_vel(22'(j.item.second_vx) + vshift[0]);
        out_d.new_second_vy = sat_vel(22'(j.item.second_vy) + vshift[1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= v_q[P_END];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

[verif/tb_top.sv]
// Self-checking regression bench for the disc pair collision response unit.
module tb_top import cpcr_pkg::*; ();

  localparam int unsigned MAX_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam logic [2:0] ADDR_RADIUS = 3'd0;
  localparam logic [2:0] ADDR_RESTITUTION = 3'd4;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  cpcr_in_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  cpcr_out_t   out_data_o;

  // The bench keeps its own copy of the two configuration registers.
  logic [13:0] radius_q;
  logic [15:0] restitution_q;

  // Expected responses, oldest first.
  cpcr_out_t   response_queue[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned stall_mode;

  circle_pair_collision_response_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The cycle counter guards against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("circle_pair_collision_response_unit regression: fail");
      $finish;
    end
  end

  function automatic logic signed [63:0] saturate(input logic signed [63:0] v,
                                                  input int unsigned w);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Integer square root of a 64-bit value, bit by bit.
  function automatic logic [63:0] root_of(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Quotient rounded half away from zero, with the sign applied afterwards.
  function automatic logic signed [63:0] div_round(input logic neg, input logic [63:0] num,
                                                   input logic [63:0] den);
    logic [63:0] q;
    q = (num + den / 2) / den;
    return neg ? -$signed(q) : $signed(q);
  endfunction

  // Works out the response of the unit to one pair under the current registers.
  function automatic cpcr_out_t collide_pair(input cpcr_in_t p);
    cpcr_out_t          o;
    logic signed [63:0] x1, y1, vx1, vy1, x2, y2, vx2, vy2;
    logic signed [63:0] dx, dy, r, sx, sy, dot, ix, iy;
    logic [63:0]        d2, lim, root_d, gap, adx, ady, k, mdot, den;
    x1 = p.first_x;   y1 = p.first_y;   vx1 = p.first_vx;  vy1 = p.first_vy;
    x2 = p.second_x;  y2 = p.second_y;  vx2 = p.second_vx; vy2 = p.second_vy;
    r = $signed({50'd0, radius_q});
    dx = x2 - x1;
    dy = y2 - y1;
    d2 = dx * dx + dy * dy;
    lim = 4 * r * r;
    o.overlapped = 1'b0;
    o.impulse_done = 1'b0;
    if (p.first_live && p.second_live && d2 != 0 && d2 < lim) begin
      root_d = root_of(d2 << 32);
      gap = ((2 * r) << 16) - root_d;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      sx = div_round(dx < 0, adx * gap, 2 * root_d);
      sy = div_round(dy < 0, ady * gap, 2 * root_d);
      x1 = saturate(x1 - sx, 20);
      y1 = saturate(y1 - sy, 20);
      x2 = saturate(x2 + sx, 20);
      y2 = saturate(y2 + sy, 20);
      o.overlapped = 1'b1;
      dot = (vx2 - vx1) * dx + (vy2 - vy1) * dy;
      if (dot <= 0) begin
        k = 64'd65536 + restitution_q;
        mdot = -dot;
        den = d2 * 64'd131072;
        ix = div_round(dx < 0, mdot * adx * k, den);
        iy = div_round(dy < 0, mdot * ady * k, den);
        vx1 = saturate(vx1 - ix, 16);
        vy1 = saturate(vy1 - iy, 16);
        vx2 = saturate(vx2 + ix, 16);
        vy2 = saturate(vy2 + iy, 16);
        o.impulse_done = 1'b1;
      end
    end
    o.new_first_x = x1[19:0];   o.new_first_y = y1[19:0];
    o.new_first_vx = vx1[15:0]; o.new_first_vy = vy1[15:0];
    o.new_second_x = x2[19:0];  o.new_second_y = y2[19:0];
    o.new_second_vx = vx2[15:0]; o.new_second_vy = vy2[15:0];
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    $display("[%0d] mismatch on %s: got %0h, expected %0h", cycle_count, what, got, want);
  endtask

  // Result side: stalls on its own pattern and compares every result transaction.
  always @(posedge clk_i) begin
    cpcr_out_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (response_queue.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_data_o.new_first_x), 64'd0);
      end else begin
        w = response_queue.pop_front();
        if (out_data_o.new_first_x !== w.new_first_x)
          report_mismatch("new_first_x", 64'(out_data_o.new_first_x), 64'(w.new_first_x));
        if (out_data_o.new_first_y !== w.new_first_y)
          report_mismatch("new_first_y", 64'(out_data_o.new_first_y), 64'(w.new_first_y));
        if (out_data_o.new_first_vx !== w.new_first_vx)
          report_mismatch("new_first_vx", 64'(out_data_o.new_first_vx),
                          64'(w.new_first_vx));
        if (out_data_o.new_first_vy !== w.new_first_vy)
          report_mismatch("new_first_vy", 64'(out_data_o.new_first_vy),
                          64'(w.new_first_vy));
        if (out_data_o.new_second_x !== w.new_second_x)
          report_mismatch("new_second_x", 64'(out_data_o.new_second_x),
                          64'(w.new_second_x));
        if (out_data_o.new_second_y !== w.new_second_y)
          report_mismatch("new_second_y", 64'(out_data_o.new_second_y),
                          64'(w.new_second_y));
        if (out_data_o.new_second_vx !== w.new_second_vx)
          report_mismatch("new_second_vx", 64'(out_data_o.new_second_vx),
                          64'(w.new_second_vx));
        if (out_data_o.new_second_vy !== w.new_second_vy)
          report_mismatch("new_second_vy", 64'(out_data_o.new_second_vy),
                          64'(w.new_second_vy));
        if (out_data_o.overlapped !== w.overlapped)
          report_mismatch("overlapped", 64'(out_data_o.overlapped), 64'(w.overlapped));
        if (out_data_o.impulse_done !== w.impulse_done)
          report_mismatch("impulse_done", 64'(out_data_o.impulse_done),
                          64'(w.impulse_done));
      end
    end
  end

  // The receiver stall pattern changes mode now and then: free running,
  // light random stalls, or long periodic stalls.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      default: out_ready_i <= (cycle_count % 23) > 15;
    endcase
  end

  // Burst state of the sender: items left in this burst.
  int unsigned burst_left;

  // Sends one pair transaction and records what it should produce. Valid is
  // raised at a falling edge and held until acceptance is seen at a rising edge.
  task automatic send_pair(input cpcr_in_t p);
    int unsigned gap_len;
    if (burst_left == 0) begin
      gap_len = $urandom_range(0, 6);
      if (gap_len != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap_len) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= p;
    response_queue.insert(response_queue.size(), collide_pair(p));
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic idle_sender();
    in_valid_i <= 1'b0;
    burst_left = 0;
  endtask

  // Waits until every expected result has come, then lets the pipeline empty.
  task automatic drain();
    idle_sender();
    while (response_queue.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // One APB write: a setup phase and an access phase. The caller closes the
  // transfer once its last write is done.
  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [13:0] radius, input logic [15:0] coeff);
    drain();
    write_register(ADDR_RADIUS, {18'd0, radius});
    write_register(ADDR_RESTITUTION, {16'd0, coeff});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    radius_q = radius;
    restitution_q = coeff;
  endtask

  function automatic cpcr_in_t make_pair(input int x1, input int y1, input int vx1,
                                         input int vy1, input int x2, input int y2,
                                         input int vx2, input int vy2, input logic l1,
                                         input logic l2);
    cpcr_in_t p;
    p.first_x = 20'(x1);   p.first_y = 20'(y1);
    p.first_vx = 16'(vx1); p.first_vy = 16'(vy1);
    p.second_x = 20'(x2);  p.second_y = 20'(y2);
    p.second_vx = 16'(vx2); p.second_vy = 16'(vy2);
    p.first_live = l1;
    p.second_live = l2;
    return p;
  endfunction

  // A pair with centres within 2 * radius + 2 (at most 32000) on each axis and
  // random velocities; sometimes placed at the edge of the x position range.
  function automatic cpcr_in_t touching_pair();
    cpcr_in_t p;
    int span;
    int cx;
    int cy;
    span = 2 * radius_q + 2;
    if (span > 32000) span = 32000;
    cx = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 524287 : -524288)
                                   : $signed($urandom_range(0, 1048575)) - 524288;
    cy = $signed($urandom_range(0, 1048575)) - 524288;
    p = '0;
    p.first_x = 20'(cx);
    p.first_y = 20'(cy);
    p.second_x = 20'(cx + $signed($urandom_range(0, 2 * span)) - span);
    p.second_y = 20'(cy + $signed($urandom_range(0, 2 * span)) - span);
    p.first_vx = 16'($urandom);  p.first_vy = 16'($urandom);
    p.second_vx = 16'($urandom); p.second_vy = 16'($urandom);
    p.first_live = $urandom_range(0, 15) != 0;
    p.second_live = $urandom_range(0, 15) != 0;
    return p;
  endfunction

  // Directed pairs: pass-through cases, coincident centres, extremes, and
  // the contact cases with and without approach.
  task automatic test_directed();
    set_config(14'd3072, 16'd64225);
    send_pair(make_pair(0, 0, 100, 0, 1000, 0, -100, 0, 1'b0, 1'b1));
    send_pair(make_pair(0, 0, 100, 0, 1000, 0, -100, 0, 1'b1, 1'b0));
    send_pair(make_pair(0, 0, 100, 0, 1000, 0, -100, 0, 1'b0, 1'b0));
    send_pair(make_pair(500, 500, 1, 2, 500, 500, 3, 4, 1'b1, 1'b1));
    send_pair(make_pair(0, 0, 100, 0, 1000, 0, -100, 0, 1'b1, 1'b1));
    send_pair(make_pair(0, 0, -100, 0, 1000, 0, 100, 0, 1'b1, 1'b1));
    send_pair(make_pair(0, 0, 0, 50, 1000, 0, 0, -50, 1'b1, 1'b1));
    send_pair(make_pair(0, 0, 0, 0, 6143, 0, 0, 0, 1'b1, 1'b1));
    send_pair(make_pair(0, 0, 0, 0, 6144, 0, 0, 0, 1'b1, 1'b1));
    send_pair(make_pair(0, 0, 0, 0, 1, 0, 0, 0, 1'b1, 1'b1));
    send_pair(make_pair(524287, 524287, 32767, 32767, 524000, 524000,
                        -32768, -32768, 1'b1, 1'b1));
    send_pair(make_pair(-524288, -524288, -32768, -32768, -524000, -524000,
                        32767, 32767, 1'b1, 1'b1));
    send_pair(make_pair(-524288, 524287, -32768, 32767, 524287, -524288,
                        32767, -32768, 1'b1, 1'b1));
    send_pair(make_pair(0, 0, 32767, -32768, -3, 4, -32768, 32767, 1'b1, 1'b1));
    set_config(14'd0, 16'd0);
    send_pair(make_pair(0, 0, 100, 0, 1, 0, -100, 0, 1'b1, 1'b1));
    set_config(14'd16383, 16'd65535);
    send_pair(make_pair(0, 0, 32767, 32767, 100, 100, -32768, -32768, 1'b1, 1'b1));
    send_pair(make_pair(0, 0, 0, 0, 32766, 0, 0, 0, 1'b1, 1'b1));
    send_pair(make_pair(0, 0, 20000, 0, -23000, 23000, -20000, 0, 1'b1, 1'b1));
  endtask

  // Random phases under several register settings; most pairs are placed
  // near contact, the rest are fully random pairs.
  task automatic test_random();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_config(14'd3072, 16'd64225);
        1: set_config(14'd16383, 16'd0);
        2: set_config(14'd1, 16'd65535);
        3: set_config(14'd0, 16'd32768);
        default: set_config(14'($urandom), 16'($urandom));
      endcase
      for (int n = 0; n < 150; n++) begin
        if ($urandom_range(0, 4) == 0) send_pair(cpcr_in_t'({$urandom, $urandom, $urandom,
                                                              $urandom, $urandom,
                                                              2'($urandom)}));
        else send_pair(touching_pair());
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b1;
    stall_mode = 0;
    burst_left = 0;
    error_count = 0;
    cycle_count = 0;
    radius_q = RADIUS_RESET;
    restitution_q = RESTITUTION_RESET;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random();
    drain();
    if (error_count == 0) begin
      $display("circle_pair_collision_response_unit regression: pass");
    end else begin
      $display("circle_pair_collision_response_unit regression: fail");
    end
    $finish;
  end

endmodule
